FILE: design/xyfp_pkg.sv
// Shared constants and types for the XY frame parser.
// No dependencies; imported by every module of the parser.
package xyfp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CoordW   = 16;
  localparam int unsigned FrameLen = 7;
  localparam int unsigned CountW   = $clog2(FrameLen);
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = ByteW;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgHeadIdx = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgTailIdx = 1'd1;

  localparam logic [ByteW-1:0] HeadReset = 8'hFF;
  localparam logic [ByteW-1:0] TailReset = 8'hFE;

  // Byte positions within a frame.
  localparam logic [CountW-1:0] PosHead = 3'd0;
  localparam logic [CountW-1:0] PosXHi  = 3'd1;
  localparam logic [CountW-1:0] PosXLo  = 3'd2;
  localparam logic [CountW-1:0] PosYHi  = 3'd3;
  localparam logic [CountW-1:0] PosYLo  = 3'd4;
  localparam logic [CountW-1:0] PosChk  = 3'd5;
  localparam logic [CountW-1:0] PosTail = 3'd6;

  typedef struct packed {
    logic [ByteW-1:0] head_byte;
    logic [ByteW-1:0] tail_byte;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [ByteW-1:0]  rx_byte;
  } byte_req_t;

  typedef struct packed {
    logic              valid;
    logic [CoordW-1:0] coord_x;
    logic [CoordW-1:0] coord_y;
  } coord_res_t;

endpackage

FILE: design/xyfp_byte_if.sv
// Valid/ready channel carrying one received byte per request.
// Depends on xyfp_pkg for the byte width.
interface xyfp_byte_if import xyfp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: design/xyfp_coord_if.sv
// Valid/ready channel carrying one decoded coordinate pair per request.
// Depends on xyfp_pkg for the coordinate width.
interface xyfp_coord_if import xyfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] coord_x;
  logic [CoordW-1:0] coord_y;

  modport source (output valid, output coord_x, output coord_y, input ready);
  modport sink   (input valid, input coord_x, input coord_y, output ready);
endinterface

FILE: design/xyfp_in_stage.sv
// Input register of the parser: captures one byte request per cycle unless the held one is stalled.
// Depends on xyfp_pkg.
module xyfp_in_stage import xyfp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [ByteW-1:0] in_byte_i,
  output logic             in_ready_o,
  input  logic             advance_i,
  output byte_req_t        req_o
);

  logic             valid_q;
  logic [ByteW-1:0] byte_q;

  // Take a new byte when empty or when the held one moves on this cycle.
  assign in_ready_o = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
    end
  end

  assign req_o.valid   = valid_q;
  assign req_o.rx_byte = byte_q;

endmodule

FILE: design/xyfp_parser.sv
// Frame tracker: byte counter, running XOR, stored coordinates and check byte.
// Depends on xyfp_pkg; produces a result pulse on the completing tail byte.
module xyfp_parser import xyfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  byte_req_t  req_i,
  input  logic       advance_i,
  output coord_res_t res_o
);

  logic [CountW-1:0] count_q, count_d;
  logic [ByteW-1:0]  xor_q, xor_d;
  logic [CoordW-1:0] x_q, x_d;
  logic [CoordW-1:0] y_q, y_d;
  logic [ByteW-1:0]  chk_q, chk_d;
  logic              fire;
  logic              frame_ok;
  logic [ByteW-1:0]  b;

  assign fire = req_i.valid && advance_i;
  assign b    = req_i.rx_byte;

  assign frame_ok = (b == cfg_i.tail_byte) && (chk_q == xor_q);

  always_comb begin
    count_d = count_q;
    xor_d   = xor_q ^ b;
    x_d     = x_q;
    y_d     = y_q;
    chk_d   = chk_q;
    case (count_q)
      PosHead: begin
        xor_d = b;
        if (b == cfg_i.head_byte) begin
          count_d = PosXHi;
        end
      end
      PosXHi: begin
        x_d[CoordW-1:ByteW] = b;
        count_d = PosXLo;
      end
      PosXLo: begin
        x_d[ByteW-1:0] = b;
        count_d = PosYHi;
      end
      PosYHi: begin
        y_d[CoordW-1:ByteW] = b;
        count_d = PosYLo;
      end
      PosYLo: begin
        y_d[ByteW-1:0] = b;
        count_d = PosChk;
      end
      PosChk: begin
        chk_d   = b;
        xor_d   = xor_q;
        count_d = PosTail;
      end
      PosTail: begin
        count_d = PosHead;
      end
      default: begin
        count_d = PosHead;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= PosHead;
    end else if (fire) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      xor_q <= xor_d;
      x_q   <= x_d;
      y_q   <= y_d;
      chk_q <= chk_d;
    end
  end

  assign res_o.valid   = fire && (count_q == PosTail) && frame_ok;
  assign res_o.coord_x = x_q;
  assign res_o.coord_y = y_q;

endmodule

FILE: design/xyfp_out_stage.sv
// Result register: holds one coordinate pair until the sink takes it.
// Depends on xyfp_pkg.
module xyfp_out_stage import xyfp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  coord_res_t        res_i,
  input  logic              out_ready_i,
  output logic              advance_o,
  output logic              out_valid_o,
  output logic [CoordW-1:0] out_x_o,
  output logic [CoordW-1:0] out_y_o
);

  logic              valid_q;
  logic [CoordW-1:0] x_q;
  logic [CoordW-1:0] y_q;

  // The slot frees up when empty or when drained this cycle.
  assign advance_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_i.valid) begin
      x_q <= res_i.coord_x;
      y_q <= res_i.coord_y;
    end
  end

  assign out_valid_o = valid_q;
  assign out_x_o     = x_q;
  assign out_y_o     = y_q;

endmodule

FILE: design/xy_frame_parser_xor_check_core.sv
// XY frame parser with XOR block check, top level.
// A result reaches out_if through the input register and the result register once its tail
// byte request is accepted. Throughput: one byte per cycle; the input register, the parser
// update and the result register form a two-stage pipeline stalled only by out_if.
// Reset: asynchronous, active low; clears the byte counter and valid flags, and
// loads head_byte 0xFF and tail_byte 0xFE. Frame storage is not cleared.
module xy_frame_parser_xor_check_core import xyfp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  xyfp_byte_if.sink           in_if,
  xyfp_coord_if.source        out_if,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t       cfg_q;
  byte_req_t  req;
  coord_res_t res;
  logic       advance;

  // Configuration registers: head and tail byte values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.head_byte <= HeadReset;
      cfg_q.tail_byte <= TailReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgHeadIdx: cfg_q.head_byte <= cfg_data_i[ByteW-1:0];
        CfgTailIdx: cfg_q.tail_byte <= cfg_data_i[ByteW-1:0];
        default:    cfg_q           <= cfg_q;
      endcase
    end
  end

  // Stage one: register the incoming byte request.
  xyfp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_byte_i  (in_if.rx_byte),
    .in_ready_o (in_if.ready),
    .advance_i  (advance),
    .req_o      (req)
  );

  // Frame tracking and checks; advance only while the result slot has room.
  xyfp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .req_i     (req),
    .advance_i (advance),
    .res_o     (res)
  );

  // Stage two: hold a good frame's coordinates until the sink takes them.
  xyfp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .out_ready_i (out_if.ready),
    .advance_o   (advance),
    .out_valid_o (out_if.valid),
    .out_x_o     (out_if.coord_x),
    .out_y_o     (out_if.coord_y)
  );

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for xy_frame_parser_xor_check_core: a byte stream in, coordinate pairs out.
// Depends on xyfp_pkg, xyfp_byte_if and xyfp_coord_if from the design folder.
module tb_top;
  import xyfp_pkg::*;

  localparam int unsigned NumPhases    = 8;
  localparam int unsigned PhaseBytes   = 182;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned LongHold     = 120;
  localparam int unsigned CycleLimit   = 400_000;
  localparam int unsigned DirRows      = 23;

  // How a directed row is checked: by the predictor, against a value typed in, or as giving no pair.
  typedef enum logic [1:0] {ROW_PREDICT, ROW_QUIET, ROW_RESULT} row_kind_e;
  // Shapes of byte sequence the random part strings together.
  typedef enum logic [2:0] {FR_GOOD, FR_BAD_CHECK, FR_BAD_TAIL, FR_NOISE, FR_CUT} frame_kind_e;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } coord_t;

  typedef struct packed {
    logic [ByteW-1:0]  rx_byte;
    row_kind_e         kind;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  xyfp_byte_if  rx_ch ();
  xyfp_coord_if coord_ch ();

  xy_frame_parser_xor_check_core dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_if     (rx_ch),
    .out_if    (coord_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  always #4 clk_i = ~clk_i;

  // Predictor state: its own copy of the registers and the partial frame.
  logic [ByteW-1:0] head_cfg;
  logic [ByteW-1:0] tail_cfg;
  int unsigned      bytes_held;
  logic [ByteW-1:0] frame_buf [FrameLen];

  coord_t           coord_expect_q [$];
  logic [ByteW-1:0] rx_plan_q [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned stall_budget;
  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned bytes_sent;
  int unsigned pairs_checked;

  // Directed stream under the reset registers (head 0xFF, tail 0xFE).
  row_t dir_table [DirRows] = '{
    // idle noise: a zero byte, then the tail value, both dropped
    '{8'h00, ROW_QUIET,   16'h0000, 16'h0000},
    '{8'hFE, ROW_QUIET,   16'h0000, 16'h0000},
    // good frame, x all zeros, y all ones, head value used as data
    '{8'hFF, ROW_PREDICT, 16'h0000, 16'h0000},
    '{8'h00, ROW_PREDICT, 16'h0000, 16'h0000},
    '{8'h00, ROW_PREDICT, 16'h0000, 16'h0000},
    '{8'hFF, ROW_PREDICT, 16'h0000, 16'h0000},
    '{8'hFF, ROW_PREDICT, 16'h0000, 16'h0000},
    '{8'hFF, ROW_PREDICT, 16'h0000, 16'h0000},
    '{8'hFE, ROW_RESULT,  16'h0000, 16'hFFFF},
    // wrong check byte; a head value inside must not restart the frame
    '{8'hFF, ROW_PREDICT, 16'h0000, 16'h0000},
    '{8'h12, ROW_PREDICT, 16'h0000, 16'h0000},
    '{8'hFF, ROW_PREDICT, 16'h0000, 16'h0000},
    '{8'h56, ROW_PREDICT, 16'h0000, 16'h0000},
    '{8'h78, ROW_PREDICT, 16'h0000, 16'h0000},
    '{8'h00, ROW_PREDICT, 16'h0000, 16'h0000},
    '{8'hFE, ROW_QUIET,   16'h0000, 16'h0000},
    // correct check, wrong tail equal to the head value: nothing, back to idle
    '{8'hFF, ROW_PREDICT, 16'h0000, 16'h0000},
    '{8'h12, ROW_PREDICT, 16'h0000, 16'h0000},
    '{8'h34, ROW_PREDICT, 16'h0000, 16'h0000},
    '{8'h56, ROW_PREDICT, 16'h0000, 16'h0000},
    '{8'h78, ROW_PREDICT, 16'h0000, 16'h0000},
    '{8'hF7, ROW_PREDICT, 16'h0000, 16'h0000},
    '{8'hFF, ROW_QUIET,   16'h0000, 16'h0000}
  };

  // Register settings per phase; the last two are drawn at random.
  logic [ByteW-1:0] phase_head [NumPhases] = '{8'hFF, 8'h00, 8'hA5, 8'h55,
                                               8'h00, 8'hFF, 8'h3C, 8'hC3};
  logic [ByteW-1:0] phase_tail [NumPhases] = '{8'hFE, 8'hFF, 8'h5A, 8'h55,
                                               8'h00, 8'h00, 8'hC3, 8'h3C};

  // Advance the frame tracker by one accepted byte; flag a decoded pair.
  task automatic parse_rx_byte(input logic [ByteW-1:0] b, output bit produced,
                               output coord_t pair);
    logic [ByteW-1:0] fold;
    produced = 1'b0;
    pair     = '0;
    // drop anything but the head while hunting
    if (bytes_held == 0 && b != head_cfg) return;
    frame_buf[bytes_held] = b;
    bytes_held++;
    if (bytes_held < FrameLen) return;
    bytes_held = 0;
    fold = frame_buf[PosHead] ^ frame_buf[PosXHi] ^ frame_buf[PosXLo] ^
           frame_buf[PosYHi] ^ frame_buf[PosYLo];
    if (frame_buf[PosTail] != tail_cfg || frame_buf[PosChk] != fold) return;
    produced = 1'b1;
    pair.x   = {frame_buf[PosXHi], frame_buf[PosXLo]};
    pair.y   = {frame_buf[PosYHi], frame_buf[PosYLo]};
  endtask

  // Offer one byte request, idling first at the phase's rate; return once accepted.
  task automatic offer_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_ch.ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Write both registers in back-to-back cycles and mirror them in the predictor.
  task automatic apply_setting(input logic [ByteW-1:0] head, input logic [ByteW-1:0] tail);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgHeadIdx;
    cfg_data <= head;
    @(posedge clk_i);
    cfg_idx  <= CfgTailIdx;
    cfg_data <= tail;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    head_cfg = head;
    tail_cfg = tail;
  endtask

  // Hold the sender until every pair is out, then let the pipe settle.
  task automatic wait_drained();
    rx_ch.valid <= 1'b0;
    while (coord_expect_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [CoordW-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return CoordW'($urandom);
    endcase
  endfunction

  // Append one byte sequence of the given shape to the plan, built for the current registers.
  task automatic plan_frame(input frame_kind_e kind);
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [ByteW-1:0]  chk;
    logic [ByteW-1:0]  tail;
    int unsigned       n;
    x    = pick_coord();
    y    = pick_coord();
    chk  = head_cfg ^ x[15:8] ^ x[7:0] ^ y[15:8] ^ y[7:0];
    tail = tail_cfg;
    case (kind)
      FR_NOISE: begin
        // stray bytes; a random one may well equal the head
        n = $urandom_range(1, 4);
        repeat (n) rx_plan_q.push_back(ByteW'($urandom));
        return;
      end
      FR_CUT: begin
        // a head and a few bytes; whatever follows fills up this frame
        rx_plan_q.push_back(head_cfg);
        n = $urandom_range(1, 5);
        repeat (n) rx_plan_q.push_back(ByteW'($urandom));
        return;
      end
      FR_BAD_CHECK: chk  = chk ^ (8'h01 << $urandom_range(0, 7));
      FR_BAD_TAIL:  tail = tail ^ ByteW'($urandom_range(1, 255));
      default: ;
    endcase
    rx_plan_q.push_back(head_cfg);
    rx_plan_q.push_back(x[15:8]);
    rx_plan_q.push_back(x[7:0]);
    rx_plan_q.push_back(y[15:8]);
    rx_plan_q.push_back(y[7:0]);
    rx_plan_q.push_back(chk);
    rx_plan_q.push_back(tail);
  endtask

  // Receiver: stall at the phase's rate, or hold off entirely while a long stall runs.
  always @(posedge clk_i) begin
    if (stall_budget > 0) begin
      stall_budget--;
      coord_ch.ready <= 1'b0;
    end else begin
      coord_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Checker: compare each accepted pair with the oldest expected one.
  always @(posedge clk_i) begin
    coord_t want;
    if (rst_ni && coord_ch.valid && coord_ch.ready) begin
      if (coord_expect_q.size() == 0) begin
        $error("coordinate pair x=%h y=%h with none expected", coord_ch.coord_x,
               coord_ch.coord_y);
        mismatches++;
      end else begin
        want = coord_expect_q.pop_front();
        pairs_checked++;
        if (coord_ch.coord_x !== want.x) begin
          $error("coord_x: expected %h, got %h", want.x, coord_ch.coord_x);
          mismatches++;
        end
        if (coord_ch.coord_y !== want.y) begin
          $error("coord_y: expected %h, got %h", want.y, coord_ch.coord_y);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d pairs outstanding", cycle_count,
               coord_expect_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    bit          got;
    coord_t      pair;
    logic [ByteW-1:0] b;
    int unsigned roll;

    rst_ni           = 1'b0;
    rx_ch.valid      = 1'b0;
    rx_ch.rx_byte    = '0;
    coord_ch.ready   = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CfgHeadIdx;
    cfg_data         = '0;
    head_cfg         = HeadReset;
    tail_cfg         = TailReset;
    bytes_held       = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    stall_budget     = 0;
    cycle_count      = 0;
    mismatches       = 0;
    bytes_sent       = 0;
    pairs_checked    = 0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: walk the table at full rate under the reset registers.
    foreach (dir_table[i]) begin
      offer_byte(dir_table[i].rx_byte);
      parse_rx_byte(dir_table[i].rx_byte, got, pair);
      case (dir_table[i].kind)
        ROW_PREDICT: if (got) coord_expect_q.push_back(pair);
        ROW_RESULT:  coord_expect_q.push_back('{x: dir_table[i].x, y: dir_table[i].y});
        default: ;
      endcase
    end

    // Random part: one register setting per phase, cycling through the idling modes.
    // A partial frame may straddle a phase boundary, so register writes land mid-frame.
    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      wait_drained();
      if (ph >= 6) begin
        phase_head[ph] = ByteW'($urandom);
        phase_tail[ph] = ByteW'($urandom);
      end
      if (ph != 0) apply_setting(phase_head[ph], phase_tail[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      // Back up the output for a long stretch while bytes keep coming.
      if (ph == 0) stall_budget = LongHold;

      while (rx_plan_q.size() < PhaseBytes) begin
        roll = $urandom_range(0, 99);
        if (roll < 70)      plan_frame(FR_GOOD);
        else if (roll < 78) plan_frame(FR_BAD_CHECK);
        else if (roll < 85) plan_frame(FR_BAD_TAIL);
        else if (roll < 93) plan_frame(FR_NOISE);
        else                plan_frame(FR_CUT);
      end
      while (rx_plan_q.size() != 0) begin
        b = rx_plan_q.pop_front();
        offer_byte(b);
        parse_rx_byte(b, got, pair);
        if (got) coord_expect_q.push_back(pair);
      end
    end

    wait_drained();
    repeat (2 * SettleCycles) @(posedge clk_i);

    $display("Sent %0d byte requests across %0d register settings and idling modes.",
             bytes_sent, NumPhases);
    $display("Checked %0d coordinate pairs, %0d mismatches.", pairs_checked, mismatches);
    if (mismatches == 0 && coord_expect_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
